@@ rtl/dpb_pkg.sv @@
// Package for the depth pixel back-projection block.
// Holds field widths, register indexes, reset values and the configuration struct.
// No dependencies; every other file but the queue refers to it by scoped names.
package dpb_pkg;

    localparam int DEPTH_W    = 16;
    localparam int COLOR_W    = 8;
    localparam int POINT_W    = 21;
    localparam int INV_W      = 24;
    localparam int INV_HALF_W = 12;
    localparam int WIDTH_W    = 13;
    localparam int CTR_W      = 16;
    localparam int FRAC_W     = 4;
    localparam int IDX_W      = 3;
    localparam int CFG_DATA_W = 24;
    localparam int ROT        = 3;
    localparam int QUEUE_DEPTH = 4;

    // Register indexes on the configuration channel
    localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH = 3'd0;
    localparam logic [IDX_W-1:0] REG_PRINCIPAL_X = 3'd1;
    localparam logic [IDX_W-1:0] REG_PRINCIPAL_Y = 3'd2;
    localparam logic [IDX_W-1:0] REG_INV_FOCAL_X = 3'd3;
    localparam logic [IDX_W-1:0] REG_INV_FOCAL_Y = 3'd4;
    localparam logic [IDX_W-1:0] REG_NEAR_LIMIT  = 3'd5;
    localparam logic [IDX_W-1:0] REG_FAR_LIMIT   = 3'd6;

    // Reset values
    localparam logic [WIDTH_W-1:0] RST_IMAGE_WIDTH = 13'd640;
    localparam logic [CTR_W-1:0]   RST_PRINCIPAL_X = 16'd5120;
    localparam logic [CTR_W-1:0]   RST_PRINCIPAL_Y = 16'd3840;
    localparam logic [INV_W-1:0]   RST_INV_FOCAL   = 24'd31957;
    localparam logic [DEPTH_W-1:0] RST_NEAR_LIMIT  = 16'd1000;
    localparam logic [DEPTH_W-1:0] RST_FAR_LIMIT   = 16'd10000;

    // Saturation bounds of a coordinate, as magnitudes one bit wider than the result
    localparam logic [POINT_W:0] POS_MAX = 22'd1048575;
    localparam logic [POINT_W:0] NEG_MAG = 22'd1048576;

    typedef struct packed {
        logic [WIDTH_W-1:0] image_width;
        logic [CTR_W-1:0]   principal_x;
        logic [CTR_W-1:0]   principal_y;
        logic [INV_W-1:0]   inv_focal_x;
        logic [INV_W-1:0]   inv_focal_y;
        logic [DEPTH_W-1:0] near_limit;
        logic [DEPTH_W-1:0] far_limit;
    } dpb_cfg_t;

    // Width of an offset magnitude: the pixel position with fraction bits, or the center
    function automatic int off_width(input int coord_bits);
        return (coord_bits + FRAC_W > CTR_W) ? coord_bits + FRAC_W : CTR_W;
    endfunction

    // Width of one queued request: two offsets with signs, depth, colors, kept, frame start
    function automatic int item_width(input int coord_bits);
        return 2 * off_width(coord_bits) + 2 + DEPTH_W + 3 * COLOR_W + 2;
    endfunction

    // Undo the stored rotation: rotate right by three
    function automatic logic [DEPTH_W-1:0] decode_depth(input logic [DEPTH_W-1:0] raw);
        return {raw[ROT-1:0], raw[DEPTH_W-1:ROT]};
    endfunction

endpackage

@@ rtl/dpb_if.sv @@
// Channel interfaces of the depth pixel back-projection block.
// Pixel input, point output and configuration write channels; uses dpb_pkg.
interface dpb_pixel_if;
    logic                          valid;
    logic                          ready;
    logic [dpb_pkg::DEPTH_W-1:0]   depth_raw;
    logic [dpb_pkg::COLOR_W-1:0]   color_ch0;
    logic [dpb_pkg::COLOR_W-1:0]   color_ch1;
    logic [dpb_pkg::COLOR_W-1:0]   color_ch2;
    logic                          frame_start;

    modport source (output valid, depth_raw, color_ch0, color_ch1, color_ch2, frame_start,
                    input ready);
    modport sink   (input valid, depth_raw, color_ch0, color_ch1, color_ch2, frame_start,
                    output ready);
endinterface

interface dpb_point_if;
    logic                               valid;
    logic                               ready;
    logic signed [dpb_pkg::POINT_W-1:0] point_x;
    logic signed [dpb_pkg::POINT_W-1:0] point_y;
    logic [dpb_pkg::DEPTH_W-1:0]        point_z;
    logic [dpb_pkg::COLOR_W-1:0]        out_ch0;
    logic [dpb_pkg::COLOR_W-1:0]        out_ch1;
    logic [dpb_pkg::COLOR_W-1:0]        out_ch2;
    logic                               point_kept;
    logic                               out_frame_start;

    modport source (output valid, point_x, point_y, point_z, out_ch0, out_ch1, out_ch2,
                    point_kept, out_frame_start, input ready);
    modport sink   (input valid, point_x, point_y, point_z, out_ch0, out_ch1, out_ch2,
                    point_kept, out_frame_start, output ready);
endinterface

interface dpb_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [dpb_pkg::IDX_W-1:0]        index;
    logic [dpb_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/dpb_regs.sv @@
// Configuration register file of the depth pixel back-projection block.
// Takes writes from the configuration channel; uses dpb_pkg and dpb_if.
module dpb_regs
(
    input  logic              clk,
    input  logic              rst_n,
    dpb_cfg_if.sink           cfg,
    output dpb_pkg::dpb_cfg_t regs
);

    dpb_pkg::dpb_cfg_t regs_reg;
    dpb_pkg::dpb_cfg_t regs_next;

    // Always accept a write request
    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    // Decode the register index; drop writes beyond the list
    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                dpb_pkg::REG_IMAGE_WIDTH:
                    regs_next.image_width = cfg.data[dpb_pkg::WIDTH_W-1:0];
                dpb_pkg::REG_PRINCIPAL_X:
                    regs_next.principal_x = cfg.data[dpb_pkg::CTR_W-1:0];
                dpb_pkg::REG_PRINCIPAL_Y:
                    regs_next.principal_y = cfg.data[dpb_pkg::CTR_W-1:0];
                dpb_pkg::REG_INV_FOCAL_X:
                    regs_next.inv_focal_x = cfg.data[dpb_pkg::INV_W-1:0];
                dpb_pkg::REG_INV_FOCAL_Y:
                    regs_next.inv_focal_y = cfg.data[dpb_pkg::INV_W-1:0];
                dpb_pkg::REG_NEAR_LIMIT:
                    regs_next.near_limit = cfg.data[dpb_pkg::DEPTH_W-1:0];
                dpb_pkg::REG_FAR_LIMIT:
                    regs_next.far_limit = cfg.data[dpb_pkg::DEPTH_W-1:0];
                default:
                    regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.image_width <= dpb_pkg::RST_IMAGE_WIDTH;
            regs_reg.principal_x <= dpb_pkg::RST_PRINCIPAL_X;
            regs_reg.principal_y <= dpb_pkg::RST_PRINCIPAL_Y;
            regs_reg.inv_focal_x <= dpb_pkg::RST_INV_FOCAL;
            regs_reg.inv_focal_y <= dpb_pkg::RST_INV_FOCAL;
            regs_reg.near_limit  <= dpb_pkg::RST_NEAR_LIMIT;
            regs_reg.far_limit   <= dpb_pkg::RST_FAR_LIMIT;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

@@ rtl/dpb_front.sv @@
// Front end of the depth pixel back-projection block: accepts pixels, tracks
// raster position, decodes depth and forms signed offsets. Uses dpb_pkg and dpb_if.
module dpb_front #(
    parameter int COORD_BITS = 12
)
(
    input  logic                                        clk,
    input  logic                                        rst_n,
    dpb_pixel_if.sink                                   pixel,
    input  dpb_pkg::dpb_cfg_t                           cfg,
    input  logic                                        q_full,
    output logic                                        push,
    output logic [dpb_pkg::item_width(COORD_BITS)-1:0]  item
);

    localparam int OFFW = dpb_pkg::off_width(COORD_BITS);
    localparam int WW   = (COORD_BITS + 1 > dpb_pkg::WIDTH_W) ? COORD_BITS + 1
                                                              : dpb_pkg::WIDTH_W;

    logic [COORD_BITS-1:0]        col_reg, col_next;
    logic [COORD_BITS-1:0]        row_reg, row_next;
    logic [COORD_BITS-1:0]        col_cur, row_cur;
    logic [WW-1:0]                width_ext, span, eff_width, col_inc;
    logic                         wrap;
    logic [OFFW:0]                off_x, off_y;
    logic [dpb_pkg::DEPTH_W-1:0]  depth;
    logic                         kept;

    // Signed offset of a pixel position from a center with four fraction bits
    function automatic logic [OFFW:0] offset_of(input logic [COORD_BITS-1:0] pos,
                                                input logic [dpb_pkg::CTR_W-1:0] ctr);
        logic [OFFW-1:0] p16;
        logic [OFFW-1:0] c;
        logic            neg;
        p16 = OFFW'({pos, {dpb_pkg::FRAC_W{1'b0}}});
        c   = OFFW'(ctr);
        neg = p16 < c;
        return neg ? {1'b1, c - p16} : {1'b0, p16 - c};
    endfunction

    assign pixel.ready = !q_full;
    assign push        = pixel.valid && !q_full;

    // Frame start forces row and column zero for this pixel
    assign col_cur = pixel.frame_start ? '0 : col_reg;
    assign row_cur = pixel.frame_start ? '0 : row_reg;

    // Advance the raster position; out-of-range widths act as the full counter span
    always_comb
    begin
        width_ext = WW'(cfg.image_width);
        span      = WW'(1) << COORD_BITS;
        eff_width = (width_ext == '0 || width_ext > span) ? span : width_ext;
        col_inc   = WW'(col_cur) + WW'(1);
        wrap      = col_inc >= eff_width;
        col_next  = wrap ? '0 : col_inc[COORD_BITS-1:0];
        row_next  = wrap ? row_cur + COORD_BITS'(1) : row_cur;
    end

    // Classify the pixel and form the queued request
    always_comb
    begin
        depth = dpb_pkg::decode_depth(pixel.depth_raw);
        kept  = (depth > cfg.near_limit) && (depth < cfg.far_limit);
        off_x = offset_of(col_cur, cfg.principal_x);
        off_y = offset_of(row_cur, cfg.principal_y);
        item  = {off_x[OFFW-1:0], off_x[OFFW], off_y[OFFW-1:0], off_y[OFFW], depth,
                 pixel.color_ch0, pixel.color_ch1, pixel.color_ch2, kept,
                 pixel.frame_start};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (push)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

@@ rtl/dpb_queue.sv @@
// Short request queue between front and back of the depth pixel back-projection block.
// Register-based, first in first out; no dependencies.
module dpb_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic             rvalid,
    output logic [WIDTH-1:0] rdata
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]    count_reg;

    assign full   = count_reg == CW'(DEPTH);
    assign rvalid = count_reg != '0;
    assign rdata  = entry_reg[rd_ptr_reg];

    // Store a request
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) push |-> (!full || pop))
        else $error("queue written while full");
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> rvalid)
        else $error("queue read while empty");
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + CW'(1))
        else $error("queue fill count lost a request");

endmodule

@@ rtl/dpb_axis.sv @@
// One coordinate axis of the back end: offset times depth times reciprocal focal
// length, rounded and saturated over three stages. Uses dpb_pkg.
module dpb_axis #(
    parameter int OFFW            = 16,
    parameter int RECIP_FRAC_BITS = 24
)
(
    input  logic                               clk,
    input  logic                               en,
    input  logic [OFFW-1:0]                    off,
    input  logic                               neg,
    input  logic [dpb_pkg::DEPTH_W-1:0]        depth,
    input  logic [dpb_pkg::INV_W-1:0]          inv,
    output logic signed [dpb_pkg::POINT_W-1:0] coord
);

    localparam int P1W  = OFFW + dpb_pkg::DEPTH_W;
    localparam int PPW  = P1W + dpb_pkg::INV_HALF_W;
    localparam int PW   = P1W + dpb_pkg::INV_W;
    localparam int SH   = dpb_pkg::FRAC_W + RECIP_FRAC_BITS;
    localparam int MW   = PW + 1 - SH;
    localparam int CMPW = (MW > dpb_pkg::POINT_W + 1) ? MW : dpb_pkg::POINT_W + 1;

    logic [P1W-1:0]              p1_reg;
    logic                        neg1_reg, neg2_reg;
    logic [PPW-1:0]              ph_reg, pl_reg;
    logic [PW:0]                 sum;
    logic [CMPW-1:0]             mag, lim, sat;
    logic [CMPW-1:0]             neg_sat;
    logic [dpb_pkg::POINT_W-1:0] coord_reg, coord_next;

    // Round to nearest with ties away from zero, then clamp the magnitude
    always_comb
    begin
        sum        = (PW + 1)'({ph_reg, {dpb_pkg::INV_HALF_W{1'b0}}}) + (PW + 1)'(pl_reg)
                     + ((PW + 1)'(1) << (SH - 1));
        mag        = CMPW'(sum >> SH);
        lim        = neg2_reg ? CMPW'(dpb_pkg::NEG_MAG) : CMPW'(dpb_pkg::POS_MAX);
        sat        = (mag > lim) ? lim : mag;
        neg_sat    = CMPW'(0) - sat;
        coord_next = neg2_reg ? neg_sat[dpb_pkg::POINT_W-1:0] : sat[dpb_pkg::POINT_W-1:0];
    end

    // Offset times depth, then two half-width products of the reciprocal, then round
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg    <= P1W'(off) * P1W'(depth);
            neg1_reg  <= neg;
            ph_reg    <= PPW'(p1_reg) * PPW'(inv[dpb_pkg::INV_W-1:dpb_pkg::INV_HALF_W]);
            pl_reg    <= PPW'(p1_reg) * PPW'(inv[dpb_pkg::INV_HALF_W-1:0]);
            neg2_reg  <= neg1_reg;
            coord_reg <= coord_next;
        end
    end

    assign coord = signed'(coord_reg);

endmodule

@@ rtl/dpb_back.sv @@
// Back end of the depth pixel back-projection block: takes queued requests and
// runs both axes through a stalling three-stage pipeline to the output register.
// Uses dpb_pkg, dpb_if and dpb_axis.
module dpb_back #(
    parameter int COORD_BITS      = 12,
    parameter int RECIP_FRAC_BITS = 24
)
(
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        q_valid,
    input  logic [dpb_pkg::item_width(COORD_BITS)-1:0]  q_item,
    output logic                                        pop,
    input  dpb_pkg::dpb_cfg_t                           cfg,
    dpb_point_if.source                                 point
);

    localparam int OFFW = dpb_pkg::off_width(COORD_BITS);

    typedef struct packed {
        logic [dpb_pkg::DEPTH_W-1:0] depth;
        logic [dpb_pkg::COLOR_W-1:0] ch0;
        logic [dpb_pkg::COLOR_W-1:0] ch1;
        logic [dpb_pkg::COLOR_W-1:0] ch2;
        logic                        kept;
        logic                        frame_start;
    } side_t;

    logic [OFFW-1:0] off_x, off_y;
    logic            neg_x, neg_y;
    side_t           side_in;
    side_t           side_reg [3];
    logic            v1_reg, v2_reg, v3_reg;
    logic            advance;

    assign {off_x, neg_x, off_y, neg_y, side_in} = q_item;

    // Move the whole pipeline unless a finished point waits
    assign advance = !v3_reg || point.ready;
    assign pop     = advance && q_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= q_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Carry depth, colors and flags alongside the products
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            side_reg[0] <= side_in;
            side_reg[1] <= side_reg[0];
            side_reg[2] <= side_reg[1];
        end
    end

    dpb_axis #(
        .OFFW            (OFFW),
        .RECIP_FRAC_BITS (RECIP_FRAC_BITS)
    ) u_axis_x (
        .clk   (clk),
        .en    (advance),
        .off   (off_x),
        .neg   (neg_x),
        .depth (side_in.depth),
        .inv   (cfg.inv_focal_x),
        .coord (point.point_x)
    );

    dpb_axis #(
        .OFFW            (OFFW),
        .RECIP_FRAC_BITS (RECIP_FRAC_BITS)
    ) u_axis_y (
        .clk   (clk),
        .en    (advance),
        .off   (off_y),
        .neg   (neg_y),
        .depth (side_in.depth),
        .inv   (cfg.inv_focal_y),
        .coord (point.point_y)
    );

    assign point.valid           = v3_reg;
    assign point.point_z         = side_reg[2].depth;
    assign point.out_ch0         = side_reg[2].ch0;
    assign point.out_ch1         = side_reg[2].ch1;
    assign point.out_ch2         = side_reg[2].ch2;
    assign point.point_kept      = side_reg[2].kept;
    assign point.out_frame_start = side_reg[2].frame_start;

    assert property (@(posedge clk) disable iff (!rst_n) (v1_reg && advance) |=> v2_reg)
        else $error("request lost between first and second stage");
    assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && !point.ready) |=> v3_reg && $stable(side_reg[2]) && $stable(v2_reg))
        else $error("pipeline moved while the output was stalled");

endmodule

@@ rtl/depth_pixel_backprojection.sv @@
// Depth pixel back-projection, top level: one raster pixel in, one 3-D point out.
// Sustained rate is one pixel per clock while the output is not stalled; a pixel's point
// passes through the request queue and then each axis' three-stage multiply chain
// (offset times depth, then two half-width products of the reciprocal focal length,
// then a stage that rounds and saturates straight into the output register).
// A four-entry queue between the position tracker and the multiply pipeline lets
// input and output stall independently. Configuration writes are taken in any cycle
// and should be made only while no pixel is in flight.
module depth_pixel_backprojection #(
    parameter int COORD_BITS      = 12,
    parameter int RECIP_FRAC_BITS = 24
)
(
    input  logic         clk,
    input  logic         rst_n,
    dpb_cfg_if.sink      cfg,
    dpb_pixel_if.sink    pixel,
    dpb_point_if.source  point
);

    localparam int ITEM_W = dpb_pkg::item_width(COORD_BITS);

    dpb_pkg::dpb_cfg_t regs;
    logic              push, pop, q_full, q_valid;
    logic [ITEM_W-1:0] item_in, item_out;

    // Hold configuration registers
    dpb_regs u_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    // Accept and classify pixels
    dpb_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .pixel  (pixel),
        .cfg    (regs),
        .q_full (q_full),
        .push   (push),
        .item   (item_in)
    );

    // Decouple front from back
    dpb_queue #(
        .WIDTH (ITEM_W),
        .DEPTH (dpb_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wdata  (item_in),
        .full   (q_full),
        .pop    (pop),
        .rvalid (q_valid),
        .rdata  (item_out)
    );

    // Project into points
    dpb_back #(
        .COORD_BITS      (COORD_BITS),
        .RECIP_FRAC_BITS (RECIP_FRAC_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_item  (item_out),
        .pop     (pop),
        .cfg     (regs),
        .point   (point)
    );

endmodule
